// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: hdl/xs128_pkg.sv
package xs128_pkg;

    localparam int WordW = 32;
    localparam int FracW = 34;

    localparam logic [WordW-1:0] MULT_CONST = 32'd1812433253;
    localparam logic [WordW-1:0] RESET_A    = 32'd123456789;
    localparam logic [WordW-1:0] RESET_B    = 32'd362436069;
    localparam logic [WordW-1:0] RESET_C    = 32'd521288629;
    localparam logic [WordW-1:0] RESET_D    = 32'd88675123;

    localparam int ShiftA  = 11;
    localparam int ShiftD  = 19;
    localparam int ShiftT  = 8;
    localparam int ShiftSd = 30;

    // Operation codes
    localparam logic FUNC_DRAW   = 1'b0;
    localparam logic FUNC_RESEED = 1'b1;

    // Fraction interval codes
    localparam logic [1:0] MODE_CLOSED    = 2'd0;
    localparam logic [1:0] MODE_HALF_OPEN = 2'd1;
    localparam logic [1:0] MODE_OPEN      = 2'd2;

    // Reseed derive steps
    localparam logic [1:0] STEP_B = 2'd1;
    localparam logic [1:0] STEP_C = 2'd2;
    localparam logic [1:0] STEP_D = 2'd3;

    typedef struct packed {
        logic       draw;
        logic       load_seed;
        logic       derive;
        logic [1:0] step;
    } xs128_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } xs128_status_t;

endpackage

// File: hdl/xs128_ctrl.sv
`include "assert_macros.svh"

module xs128_ctrl
    import xs128_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          func,
    output logic          in_stall,
    input  xs128_status_t status,
    output xs128_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEED = 1'b1;

    logic       state_reg;
    logic       state_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE) || status.out_blocked;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd.draw       = 1'b0;
        cmd.load_seed  = 1'b0;
        cmd.derive     = 1'b0;
        cmd.step       = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_RESEED)
                    begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_SEED;
                        step_next     = STEP_B;
                    end
                    else
                    begin
                        cmd.draw = 1'b1;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.derive = 1'b1;
                if (step_reg == STEP_D)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_B;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `ASSERT_PROP(a_reseed_enters_seed, clk, rst_n, (cmd.load_seed |=> (state_reg == ST_SEED) && (step_reg == STEP_B)), "reseed did not start derive sequence")
    `ASSERT_PROP(a_seed_ends, clk, rst_n, ((state_reg == ST_SEED) && (step_reg == STEP_D) |=> state_reg == ST_IDLE), "derive sequence did not end after last step")
    `ASSERT_NEVER(a_derive_step_zero, clk, rst_n, cmd.derive && (cmd.step == 2'd0), "derive issued with no target word")

endmodule

// File: hdl/xs128_dp.sv
`include "assert_macros.svh"

module xs128_dp
    import xs128_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  xs128_cmd_t       cmd,
    output xs128_status_t    status,
    input  logic [WordW-1:0] seed,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WordW-1:0] raw_word,
    output logic [FracW-1:0] fraction
);

    logic [WordW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [WordW-1:0] a_next, b_next, c_next, d_next;
    logic [1:0]       mode_reg;
    logic             out_valid_reg;
    logic [WordW-1:0] raw_reg;
    logic [FracW-1:0] frac_reg;
    logic [FracW-1:0] frac_next;

    logic [WordW-1:0] t_val;
    logic [WordW-1:0] new_d;
    logic [WordW-1:0] prev;
    logic [WordW-1:0] mix;
    logic [WordW-1:0] prod;
    logic [WordW-1:0] derived;

    assign status.out_blocked = out_valid_reg && out_stall;

    // xorshift advance
    assign t_val = a_reg ^ (a_reg << ShiftA);
    assign new_d = d_reg ^ (d_reg >> ShiftD) ^ t_val ^ (t_val >> ShiftT);

    // Reseed recurrence through one shared multiplier
    always_comb
    begin
        case (cmd.step)
            STEP_B:  prev = a_reg;
            STEP_C:  prev = b_reg;
            default: prev = c_reg;
        endcase
    end

    assign mix     = prev ^ (prev >> ShiftSd);
    assign prod    = mix * MULT_CONST;
    assign derived = prod + {{(WordW-2){1'b0}}, cmd.step};

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        if (cmd.draw)
        begin
            a_next = b_reg;
            b_next = c_reg;
            c_next = d_reg;
            d_next = new_d;
        end
        else if (cmd.load_seed)
        begin
            a_next = seed;
        end
        else if (cmd.derive)
        begin
            case (cmd.step)
                STEP_B:  b_next = derived;
                STEP_C:  c_next = derived;
                STEP_D:  d_next = derived;
                default: d_next = d_reg;
            endcase
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_CLOSED:
                frac_next = {1'b0, new_d, 1'b0}
                          + ((&new_d) ? FracW'(2) : FracW'(0));
            MODE_OPEN:
                frac_next = {1'b0, new_d, 1'b1};
            default:
                frac_next = {1'b0, new_d, 1'b0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= RESET_A;
            b_reg         <= RESET_B;
            c_reg         <= RESET_C;
            d_reg         <= RESET_D;
            mode_reg      <= MODE_HALF_OPEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.draw)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            raw_reg  <= new_d;
            frac_reg <= frac_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign raw_word  = raw_reg;
    assign fraction  = frac_reg;

    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.draw && out_valid_reg && out_stall, "draw would overwrite a pending item")
    `ASSERT_PROP(a_draw_shows, clk, rst_n, (cmd.draw |=> out_valid_reg && (raw_reg == d_reg)), "drawn word not presented")
    `ASSERT_NEVER(a_one_cmd, clk, rst_n, (cmd.draw && cmd.load_seed) || (cmd.draw && cmd.derive) || (cmd.load_seed && cmd.derive), "conflicting datapath commands")

endmodule

// File: hdl/xorshift128_random_generator_top.sv
// xorshift128 generator. A draw item (func 0) advances the four state words
// and returns the new word as raw_word plus fraction, a value in units of
// 2^-33 whose interval follows fraction_mode (0 closed, 1 half-open, 2 open,
// 3 as half-open). Draws are accepted every cycle while the output register
// is free or being emptied. A reseed item (func 1) returns nothing: it loads
// the seed, then derives the other three words in turn through the single
// 32x32 multiplier; in_stall is held high meanwhile. cfg_ready is always
// high; write the mode only while idle.
module xorshift128_random_generator_top
    import xs128_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             func,
    input  logic [WordW-1:0] seed,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WordW-1:0] raw_word,
    output logic [FracW-1:0] fraction,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_data
);

    xs128_cmd_t    cmd;
    xs128_status_t status;

    assign cfg_ready = 1'b1;

    xs128_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    xs128_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .seed      (seed),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .raw_word  (raw_word),
        .fraction  (fraction)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import xs128_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic             op;
        logic [WordW-1:0] seed;
    } gen_item_t;

    typedef struct {
        logic [WordW-1:0] raw;
        logic [FracW-1:0] frac;
    } draw_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             func = FUNC_DRAW;
    logic [WordW-1:0] seed = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [WordW-1:0] raw_word;
    logic [FracW-1:0] fraction;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_data = MODE_HALF_OPEN;

    // Generator state and mode as the block should hold them
    logic [WordW-1:0] gen_a = RESET_A;
    logic [WordW-1:0] gen_b = RESET_B;
    logic [WordW-1:0] gen_c = RESET_C;
    logic [WordW-1:0] gen_d = RESET_D;
    logic [1:0]       frac_mode = MODE_HALF_OPEN;

    gen_item_t    pending_items[$];
    draw_result_t expected_draws[$];

    int items_queued = 0;
    int items_accepted = 0;
    int draws_checked = 0;
    int reseeds_applied = 0;
    int error_count = 0;
    int blocked_cycles = 0;
    int cycle_count = 0;
    int sender_gap_max = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int run_left = 0;
    bit run_stalled = 1'b0;
    bit [3:0] modes_used = '0;

    xorshift128_random_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .seed      (seed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .raw_word  (raw_word),
        .fraction  (fraction),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [WordW-1:0] derive_word(input logic [WordW-1:0] prev,
                                                     input int k);
        return WordW'(MULT_CONST * (prev ^ (prev >> ShiftSd)) + WordW'(k));
    endfunction

    // Apply one accepted item to the generator copy; a draw yields one result.
    function automatic void step_generator(input logic op, input logic [WordW-1:0] s);
        logic [WordW-1:0] t;
        logic [WordW-1:0] w;
        logic [FracW-1:0] f;
        draw_result_t     res;
        if (op == FUNC_RESEED)
        begin
            gen_a = s;
            gen_b = derive_word(gen_a, 1);
            gen_c = derive_word(gen_b, 2);
            gen_d = derive_word(gen_c, 3);
            reseeds_applied++;
        end
        else
        begin
            t = gen_a ^ (gen_a << ShiftA);
            w = (gen_d ^ (gen_d >> ShiftD)) ^ (t ^ (t >> ShiftT));
            gen_a = gen_b;
            gen_b = gen_c;
            gen_c = gen_d;
            gen_d = w;
            f = {2'b00, w};
            if (frac_mode == MODE_CLOSED && &w)
                f = f + 1'b1;
            f = f << 1;
            if (frac_mode == MODE_OPEN)
                f = f + 1'b1;
            res.raw = w;
            res.frac = f;
            expected_draws.push_back(res);
        end
    endfunction

    // Sender: bursts of items with random gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        gen_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= FUNC_DRAW;
            seed <= '0;
        end
        else
        begin
            if (in_valid && in_stall)
                blocked_cycles++;
            if (in_valid && !in_stall)
            begin
                step_generator(func, seed);
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    in_valid <= 1'b1;
                    func <= nxt.op;
                    seed <= nxt.seed;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = (sender_gap_max == 0) ? 0
                                                         : $urandom_range(1, sender_gap_max);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: runs of stall and no stall, plus a long hold when asked
    always @(posedge clk or negedge rst_n)
    begin
        bit next_stall;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (!hold_request)
                hold_taken = 1'b0;
            else if (!hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_stalled = ($urandom_range(0, 2) == 0);
                    run_left = run_stalled ? $urandom_range(1, 6) : $urandom_range(1, 40);
                end
                else
                begin
                    run_left--;
                end
                next_stall = run_stalled;
            end
            out_stall <= next_stall;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_draws.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual raw_word %h fraction %h",
                         $time, raw_word, fraction);
                error_count++;
            end
            else
            begin
                want = expected_draws.pop_front();
                if (raw_word !== want.raw)
                begin
                    $display("%0t: raw_word mismatch: expected %h, actual %h",
                             $time, want.raw, raw_word);
                    error_count++;
                end
                if (fraction !== want.frac)
                begin
                    $display("%0t: fraction mismatch: expected %h, actual %h",
                             $time, want.frac, fraction);
                    error_count++;
                end
                draws_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_draws.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic queue_item(input logic op, input logic [WordW-1:0] s);
        gen_item_t it;
        it.op = op;
        it.seed = s;
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [WordW-1:0] pick_seed();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WordW'(1) << $urandom_range(0, WordW - 1);
            3: return ~(WordW'(1) << $urandom_range(0, WordW - 1));
            default: return $urandom;
        endcase
    endfunction

    // Wait until every item is in and every result is out, then let a reseed finish
    task automatic wait_until_idle();
        while (items_accepted != items_queued || expected_draws.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_fraction_mode(input logic [1:0] mode);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        frac_mode = mode;
        modes_used[mode] = 1'b1;
    endtask

    task automatic run_phase(input logic [1:0] mode, input int count, input int gap_max,
                             input bit with_hold);
        set_fraction_mode(mode);
        sender_gap_max = gap_max;
        hold_request = with_hold;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 12)
                queue_item(FUNC_RESEED, pick_seed());
            else
                queue_item(FUNC_DRAW, $urandom);
        end
        wait_until_idle();
        hold_request = 1'b0;
    endtask

    initial
    begin
        logic [1:0] phase_modes[8];
        int         phase_gaps[8];
        phase_modes = '{MODE_OPEN, MODE_CLOSED, MODE_SPARE, MODE_HALF_OPEN,
                        MODE_CLOSED, MODE_OPEN, MODE_SPARE, MODE_HALF_OPEN};
        phase_gaps = '{0, 3, 1, 8, 0, 2, 5, 0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // From reset state in the reset mode; the seed on a draw is ignored
        modes_used[MODE_HALF_OPEN] = 1'b1;
        sender_gap_max = 2;
        queue_item(FUNC_DRAW, '0);
        queue_item(FUNC_DRAW, '1);
        queue_item(FUNC_DRAW, 32'hA5A5_5A5A);
        queue_item(FUNC_RESEED, '0);
        queue_item(FUNC_DRAW, '0);
        queue_item(FUNC_DRAW, '1);
        queue_item(FUNC_RESEED, '1);
        queue_item(FUNC_DRAW, '0);
        queue_item(FUNC_RESEED, 32'h8000_0000);
        queue_item(FUNC_RESEED, 32'h0000_0001);
        queue_item(FUNC_DRAW, 32'h5555_5555);
        queue_item(FUNC_DRAW, 32'hAAAA_AAAA);
        queue_item(FUNC_RESEED, 32'd123456789);
        queue_item(FUNC_DRAW, '0);
        queue_item(FUNC_DRAW, '0);
        queue_item(FUNC_DRAW, '0);
        wait_until_idle();

        for (int p = 0; p < 8; p++)
            run_phase(phase_modes[p], 98, phase_gaps[p], (p == 2 || p == 6));

        $display("Checked %0d draws and %0d reseeds, fraction modes seen %b",
                 draws_checked, reseeds_applied, modes_used);
        $display("Input held off on %0d cycles, including long output holds", blocked_cycles);
        if (error_count == 0 && expected_draws.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: xorshift128_random_generator_top.f
+incdir+hdl
hdl/xs128_pkg.sv
hdl/xs128_ctrl.sv
hdl/xs128_dp.sv
hdl/xorshift128_random_generator_top.sv
dv/testbench.sv
